FILE: rtl/ipv4p_pkg.sv
// ipv4p_pkg: types and constants shared by the dotted-decimal parser files.
// Holds the result record, parser phase codes and the character codes.
// No dependencies.
`default_nettype none

package ipv4p_pkg;

  // Parser phase codes
  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_PARSE  = 2'd1;
  localparam logic [1:0] PH_IGNORE = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [1:0]  LAST_OCTET  = 2'd3;

  // One parse result
  typedef struct packed {
    logic       ok;
    logic [7:0] octet_a;
    logic [7:0] octet_b;
    logic [7:0] octet_c;
    logic [7:0] octet_d;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ipv4p_step.sv
// ipv4p_step: parser state registers and the per-character next-state logic.
// Updates on each accepted character and flags a result when one is decided.
// Depends on ipv4p_pkg.
`default_nettype none

module ipv4p_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire logic [7:0]         ch,
  output logic                    emit,
  output ipv4p_pkg::result_t      result
);

  logic [1:0] phase, phase_next;
  logic [1:0] octet_index, octet_index_next;
  logic       digit_seen, digit_seen_next;
  logic [7:0] accumulator, accumulator_next;
  logic [7:0] stored0, stored0_next;
  logic [7:0] stored1, stored1_next;
  logic [7:0] stored2, stored2_next;

  logic        is_digit;
  logic        is_blank;
  logic        is_term;
  logic [11:0] value;

  // Character classes
  assign is_digit = (ch >= ipv4p_pkg::CH_ZERO) && (ch <= ipv4p_pkg::CH_NINE);
  assign is_blank = (ch == ipv4p_pkg::CH_SPACE) || (ch == ipv4p_pkg::CH_TAB);
  assign is_term  = (ch == ipv4p_pkg::CH_NUL) || is_blank ||
                    (ch == ipv4p_pkg::CH_CR) || (ch == ipv4p_pkg::CH_LF);

  // acc * 10 + digit, as shifts and adds
  assign value = {1'b0, accumulator, 3'b000} + {3'b000, accumulator, 1'b0} +
                 {8'h00, ch[3:0] - ipv4p_pkg::CH_ZERO[3:0]};

  // Next state and result
  always_comb begin
    logic good;
    logic fin;
    good             = 1'b0;
    fin              = 1'b0;
    phase_next       = phase;
    octet_index_next = octet_index;
    digit_seen_next  = digit_seen;
    accumulator_next = accumulator;
    stored0_next     = stored0;
    stored1_next     = stored1;
    stored2_next     = stored2;

    if (phase != ipv4p_pkg::PH_SKIP && phase != ipv4p_pkg::PH_PARSE) begin
      if (ch == ipv4p_pkg::CH_NUL) begin
        phase_next = ipv4p_pkg::PH_SKIP;
      end
    end else if (phase == ipv4p_pkg::PH_SKIP && is_blank) begin
      phase_next = phase;
    end else begin
      phase_next = ipv4p_pkg::PH_PARSE;
      if (is_digit) begin
        if (value > ipv4p_pkg::OCTET_MAX) begin
          fin = 1'b1;
        end else begin
          accumulator_next = value[7:0];
          digit_seen_next  = 1'b1;
        end
      end else if (!digit_seen) begin
        fin = 1'b1;
      end else if (octet_index != ipv4p_pkg::LAST_OCTET) begin
        if (ch != ipv4p_pkg::CH_DOT) begin
          fin = 1'b1;
        end else begin
          unique case (octet_index)
            2'd0:    stored0_next = accumulator;
            2'd1:    stored1_next = accumulator;
            default: stored2_next = accumulator;
          endcase
          octet_index_next = octet_index + 2'd1;
          accumulator_next = 8'h00;
          digit_seen_next  = 1'b0;
        end
      end else begin
        fin  = 1'b1;
        good = is_term;
      end
    end

    emit           = fin;
    result.ok      = good;
    result.octet_a = good ? stored0 : 8'h00;
    result.octet_b = good ? stored1 : 8'h00;
    result.octet_c = good ? stored2 : 8'h00;
    result.octet_d = good ? accumulator : 8'h00;

    // A decision clears the parse and picks the next phase
    if (fin) begin
      octet_index_next = 2'd0;
      digit_seen_next  = 1'b0;
      accumulator_next = 8'h00;
      stored0_next     = 8'h00;
      stored1_next     = 8'h00;
      stored2_next     = 8'h00;
      phase_next       = (ch == ipv4p_pkg::CH_NUL) ? ipv4p_pkg::PH_SKIP
                                                   : ipv4p_pkg::PH_IGNORE;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ipv4p_pkg::PH_SKIP;
      octet_index <= 2'd0;
      digit_seen  <= 1'b0;
      accumulator <= 8'h00;
      stored0     <= 8'h00;
      stored1     <= 8'h00;
      stored2     <= 8'h00;
    end else if (take) begin
      phase       <= phase_next;
      octet_index <= octet_index_next;
      digit_seen  <= digit_seen_next;
      accumulator <= accumulator_next;
      stored0     <= stored0_next;
      stored1     <= stored1_next;
      stored2     <= stored2_next;
    end
  end

  // A decision never leaves the block in the octet phase
  a_fin_leaves_parse: assert property (@(posedge clk) disable iff (rst)
    emit |-> (phase_next != ipv4p_pkg::PH_PARSE))
    else $error("decision left parser in octet phase");

endmodule

`default_nettype wire

FILE: rtl/ipv4p_skid.sv
// ipv4p_skid: two-entry output buffer (output register plus skid register).
// Lets the parser keep taking characters while one result waits.
// Depends on ipv4p_pkg.
`default_nettype none

module ipv4p_skid (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire ipv4p_pkg::result_t  push_data,
  output logic                     full,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ipv4p_pkg::result_t       out_data
);

  logic               skid_valid;
  ipv4p_pkg::result_t skid_data;
  logic               out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  // Output register fills from the skid entry first, then from the parser
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output register");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into full buffer");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.ok) |-> (out_data.octet_a == 8'h00 &&
      out_data.octet_b == 8'h00 && out_data.octet_c == 8'h00 &&
      out_data.octet_d == 8'h00))
    else $error("error result carries non-zero octets");

endmodule

`default_nettype wire

FILE: rtl/ipv4_dotted_decimal_parser.sv
// ipv4_dotted_decimal_parser: streaming IPv4 dotted-decimal address parser.
// Top level; depends on ipv4p_pkg, ipv4p_step and ipv4p_skid.
//
// Usage:
//   Input channel (in_valid, in_stall, ch) carries one character per
//   transfer; a zero byte ends a string. Leading spaces and tabs are
//   skipped, then four decimal octets separated by dots are parsed.
//   Output channel (out_valid, out_stall, ok, octet_a..octet_d) carries one
//   result per string, produced by the character that decides it; after
//   an early decision the rest of the string up to its zero byte is
//   dropped. On error ok is 0 and all octets are zero.
//   Throughput: one character per clock while in_stall is low. The parser state updates in the
//   cycle of the transfer; the whole step is one pass of short logic.
//   Result path: the result of the deciding character is registered in the output
//   register, or in the skid register while the output register holds a stalled result.
//   Stall: results queue in a two-entry buffer (output plus skid register);
//   in_stall rises only when both entries hold results, and stays low
//   otherwise, so characters keep flowing while one result waits.
//   Reset (rst, synchronous): parser returns to the leading-blank phase
//   with all octets cleared, and the output buffer empties.
`default_nettype none

module ipv4_dotted_decimal_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            ok,
  output logic [7:0]      octet_a,
  output logic [7:0]      octet_b,
  output logic [7:0]      octet_c,
  output logic [7:0]      octet_d
);

  logic               take;
  logic               emit;
  logic               full;
  ipv4p_pkg::result_t step_result;
  ipv4p_pkg::result_t out_data;

  assign in_stall = full;
  assign take     = in_valid && !full;

  // Parser state and step logic
  ipv4p_step u_step (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .ch     (ch),
    .emit   (emit),
    .result (step_result)
  );

  // Result buffer
  ipv4p_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take && emit),
    .push_data (step_result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign ok      = out_data.ok;
  assign octet_a = out_data.octet_a;
  assign octet_b = out_data.octet_b;
  assign octet_c = out_data.octet_c;
  assign octet_d = out_data.octet_d;

endmodule

`default_nettype wire

FILE: bench/tb_ipv4_dotted_decimal_parser.sv
// Testbench for ipv4_dotted_decimal_parser: streams NUL-terminated strings in and
// checks every parse result against a behavioural predictor held in the bench.
// Depends on ipv4p_pkg and the parser RTL.

module tb_ipv4_dotted_decimal_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;

  // DUT connections, all inputs known from time zero
  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] ch        = ipv4p_pkg::CH_NUL;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       ok;
  logic [7:0] octet_a;
  logic [7:0] octet_b;
  logic [7:0] octet_c;
  logic [7:0] octet_d;

  ipv4_dotted_decimal_parser u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ok        (ok),
    .octet_a   (octet_a),
    .octet_b   (octet_b),
    .octet_c   (octet_c),
    .octet_d   (octet_d)
  );

  // Stimulus and expectation stores
  logic [7:0]         char_queue[$];
  ipv4p_pkg::result_t expected_addrs[$];
  int                 chars_made;
  int                 mismatch_count = 0;
  int                 cycle_count    = 0;

  // Sender and receiver idling knobs, changed between phases
  int gap_max    = 0;
  int burst_left = 1;
  int gap_left   = 0;
  int stall_pct  = 0;
  int stall_max  = 1;
  int stall_run  = 0;
  bit stall_level;
  bit char_taken = 1'b0;

  // Predictor state
  logic [1:0] ps_phase = ipv4p_pkg::PH_SKIP;
  logic [1:0] ps_index = '0;
  logic       ps_digit = 1'b0;
  logic [7:0] ps_acc   = '0;
  logic [7:0] ps_held[3] = '{default: '0};

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Predictor
  function automatic bit is_end_char(input logic [7:0] c);
    return c == ipv4p_pkg::CH_NUL || c == ipv4p_pkg::CH_SPACE ||
           c == ipv4p_pkg::CH_TAB || c == ipv4p_pkg::CH_CR || c == ipv4p_pkg::CH_LF;
  endfunction

  task automatic clear_octets();
    ps_index = '0;
    ps_digit = 1'b0;
    ps_acc   = '0;
    ps_held  = '{default: '0};
  endtask

  // String decided: queue the address (or zeros) and pick the next phase
  task automatic close_string(input logic [7:0] c, input bit good);
    ipv4p_pkg::result_t r;
    r.ok      = good;
    r.octet_a = good ? ps_held[0] : '0;
    r.octet_b = good ? ps_held[1] : '0;
    r.octet_c = good ? ps_held[2] : '0;
    r.octet_d = good ? ps_acc : '0;
    expected_addrs.push_back(r);
    clear_octets();
    ps_phase = (c == ipv4p_pkg::CH_NUL) ? ipv4p_pkg::PH_SKIP : ipv4p_pkg::PH_IGNORE;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [11:0] v;
    if (ps_phase >= ipv4p_pkg::PH_IGNORE) begin
      if (c == ipv4p_pkg::CH_NUL) ps_phase = ipv4p_pkg::PH_SKIP;
      return;
    end
    if (ps_phase == ipv4p_pkg::PH_SKIP) begin
      if (c == ipv4p_pkg::CH_SPACE || c == ipv4p_pkg::CH_TAB) return;
      ps_phase = ipv4p_pkg::PH_PARSE;
      clear_octets();
    end
    if (c >= ipv4p_pkg::CH_ZERO && c <= ipv4p_pkg::CH_NINE) begin
      v = 12'(ps_acc) * 12'd10 + 12'(c - ipv4p_pkg::CH_ZERO);
      if (v > ipv4p_pkg::OCTET_MAX) begin
        close_string(c, 1'b0);
      end else begin
        ps_acc   = v[7:0];
        ps_digit = 1'b1;
      end
    end else if (!ps_digit) begin
      close_string(c, 1'b0);
    end else if (ps_index != ipv4p_pkg::LAST_OCTET) begin
      if (c != ipv4p_pkg::CH_DOT) begin
        close_string(c, 1'b0);
      end else begin
        ps_held[ps_index] = ps_acc;
        ps_index = ps_index + 2'd1;
        ps_acc   = '0;
        ps_digit = 1'b0;
      end
    end else begin
      close_string(c, is_end_char(c));
    end
  endtask

  // Driver: one character per transfer, bursts with random gaps
  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nc;
    nv = in_valid;
    nc = ch;
    if (rst) begin
      nv = 1'b0;
    end else if (!in_valid || char_taken) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (char_queue.size() > 0) begin
        nv = 1'b1;
        nc = char_queue.pop_front();
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
      end
    end
    in_valid <= nv;
    ch       <= nc;
  end

  // Receiver stall pattern: runs of random length
  always @(negedge clk) begin
    if (rst || stall_pct == 0) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_level = ($urandom_range(0, 99) < stall_pct);
        stall_run   = $urandom_range(1, stall_level ? stall_max : 8);
      end
      stall_run--;
      out_stall <= stall_level;
    end
  end

  // Monitor: predict on input transfers, then check output transfers
  always @(posedge clk) begin
    ipv4p_pkg::result_t want;
    if (rst) begin
      char_taken <= 1'b0;
    end else begin
      char_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) parse_char(ch);
      if (out_valid && !out_stall) begin
        if (expected_addrs.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_addrs.pop_front();
          if (ok !== want.ok)
            report_mismatch($sformatf("ok %0b, expected %0b", ok, want.ok));
          if (octet_a !== want.octet_a)
            report_mismatch($sformatf("octet_a %0d, expected %0d", octet_a, want.octet_a));
          if (octet_b !== want.octet_b)
            report_mismatch($sformatf("octet_b %0d, expected %0d", octet_b, want.octet_b));
          if (octet_c !== want.octet_c)
            report_mismatch($sformatf("octet_c %0d, expected %0d", octet_c, want.octet_c));
          if (octet_d !== want.octet_d)
            report_mismatch($sformatf("octet_d %0d, expected %0d", octet_d, want.octet_d));
        end
      end
    end
  end

  // Stimulus building
  task automatic push_byte(input logic [7:0] c);
    char_queue.push_back(c);
    chars_made++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic int pick_octet();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 255;
      2:       return $urandom_range(250, 255);
      3:       return $urandom_range(0, 9);
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic add_octet_text(input int value, input bit pad);
    if (pad) repeat ($urandom_range(1, 3)) push_byte(ipv4p_pkg::CH_ZERO);
    add_text($sformatf("%0d", value));
  endtask

  // Mostly well-formed addresses, some with one flaw, some pure noise
  task automatic add_random_string();
    int         kind;
    int         flaw;
    int         flaw_at;
    logic [7:0] term;
    kind    = $urandom_range(0, 9);
    flaw    = (kind >= 7) ? $urandom_range(1, 6) : 0;
    flaw_at = $urandom_range(0, 3);
    repeat ($urandom_range(0, 2))
      push_byte($urandom_range(0, 1) ? ipv4p_pkg::CH_SPACE : ipv4p_pkg::CH_TAB);
    if (kind == 0) begin
      repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(1, 255)));
      push_byte(ipv4p_pkg::CH_NUL);
      return;
    end
    for (int k = 0; k < 4; k++) begin
      if (k > 0) push_byte(ipv4p_pkg::CH_DOT);
      if (flaw == 1 && k == flaw_at)
        add_octet_text($urandom_range(256, 999), 1'b0);        // too large
      else if (!(flaw == 2 && k == flaw_at))                  // else digits missing
        add_octet_text(pick_octet(), $urandom_range(0, 7) == 0);
      if (flaw == 3 && k == flaw_at) push_byte(8'($urandom_range(1, 255)));
      if (flaw == 4 && k == flaw_at) begin
        push_byte(ipv4p_pkg::CH_NUL);                         // cut short
        return;
      end
    end
    if (flaw == 5) push_byte(ipv4p_pkg::CH_DOT);
    case ($urandom_range(0, 4))
      0:       term = ipv4p_pkg::CH_NUL;
      1:       term = ipv4p_pkg::CH_SPACE;
      2:       term = ipv4p_pkg::CH_TAB;
      3:       term = ipv4p_pkg::CH_CR;
      default: term = ipv4p_pkg::CH_LF;
    endcase
    if (flaw == 6) term = 8'($urandom_range(0, 255));
    push_byte(term);
    if (term != ipv4p_pkg::CH_NUL) begin
      // tail after the decision, dropped by the block up to its NUL
      repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
      push_byte(ipv4p_pkg::CH_NUL);
    end
  endtask

  // Hold the sender until every transfer is done and every result is in
  task automatic wait_idle();
    while (char_queue.size() != 0 || in_valid || expected_addrs.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings, no idling on either side
    push_byte(ipv4p_pkg::CH_NUL);                               // empty string
    push_byte(ipv4p_pkg::CH_SPACE); push_byte(ipv4p_pkg::CH_TAB);
    push_byte(ipv4p_pkg::CH_NUL);                               // blank string
    add_text("0.0.0.0");         push_byte(ipv4p_pkg::CH_NUL);
    add_text("255.255.255.255"); push_byte(ipv4p_pkg::CH_NUL);
    add_text("256.1.1.1");       push_byte(ipv4p_pkg::CH_NUL);  // overflow, then dropped
    add_text("1.2.3.300");       push_byte(ipv4p_pkg::CH_NUL);
    add_text("1..2.3");          push_byte(ipv4p_pkg::CH_NUL);  // empty octet
    add_text(".1.2.3.4");        push_byte(ipv4p_pkg::CH_NUL);
    add_text("1.2.3.");          push_byte(ipv4p_pkg::CH_NUL);  // NUL where a digit is due
    add_text("1.2.3");           push_byte(ipv4p_pkg::CH_NUL);
    add_text("1.2.3.4.");        push_byte(ipv4p_pkg::CH_NUL);  // dot after fourth octet
    add_text("1.2.x.4");         push_byte(ipv4p_pkg::CH_NUL);
    push_byte(ipv4p_pkg::CH_TAB); push_byte(ipv4p_pkg::CH_SPACE);
    add_text("007.08.009.255");  push_byte(ipv4p_pkg::CH_CR);
    add_text("junk");            push_byte(ipv4p_pkg::CH_NUL);
    add_text("10.20.30.40");     push_byte(ipv4p_pkg::CH_LF); push_byte(ipv4p_pkg::CH_NUL);
    add_text("9.99.199.249");    push_byte(ipv4p_pkg::CH_TAB); push_byte(ipv4p_pkg::CH_NUL);
    add_text("1.2.3.4 5.6.7.8"); push_byte(ipv4p_pkg::CH_NUL);  // rest ignored
    add_text("25.5.0.1");        push_byte(8'hFF); push_byte(ipv4p_pkg::CH_NUL);
    wait_idle();

    // Random phases with differing idling on each side
    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0: begin gap_max = 4;  stall_pct = 30; stall_max = 6;  end
        1: begin gap_max = 0;  stall_pct = 0;  stall_max = 1;  end
        2: begin gap_max = 8;  stall_pct = 60; stall_max = 30; end
        3: begin gap_max = 0;  stall_pct = 80; stall_max = 12; end
        default: begin gap_max = 2; stall_pct = 15; stall_max = 3; end
      endcase
      chars_made = 0;
      while (chars_made < 95) add_random_string();
      if (seg == 1 || seg == 3) wait_idle();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
